// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== hdl/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Opcodes, sequencer states and fixed field widths of the scheduler core.
// ----------------------------------------------------------------------------
package srtf_pkg;

    // Fixed widths of the item fields.
    localparam int ID_W  = 8;
    localparam int FLD_W = 16;

    // Width of one table entry: id, arrival, original burst, remaining.
    localparam int ENTRY_W = ID_W + 3 * FLD_W;

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_WB    = 6'b001000,
        S_FIN   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

endpackage

// ===== hdl/srtf_scheduler_tick_core.sv =====
// ----------------------------------------------------------------------------
// SRTF scheduler tick core
// Preemptive shortest-remaining-time-first scheduler with a table in memory.
// ----------------------------------------------------------------------------
// The process table lives in one synchronous memory with one write and one
// read port. A tick beat reads the n loaded entries one per cycle to find the
// process with the least remaining time, writes the decremented entry back and
// then issues its result. A load beat writes its entry and issues a result; a
// clear beat issues none. Beats are accepted only while the sequencer is
// idle; a finished result waits in the output register while the next beat
// is accepted.
`include "assert_macros.svh"

module srtf_scheduler_tick_core
    import srtf_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // proc_id[7:0], arrival[23:8], burst[39:24]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    // Result beats.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // run_id[7:0], now[23:8], completion[39:24],
                                       // turnaround[55:40], waiting[71:56]
    output logic [2:0]  m_axis_tuser,  // idle[0], finished[1], table_full[2]
    output logic        m_axis_tlast   // all_done
);

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int TW = TIME_BITS;
    localparam int WW = (TIME_BITS > FLD_W) ? TIME_BITS : FLD_W;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
    localparam logic [FLD_W-1:0] ARR_MASK =
        FLD_W'({FLD_W{1'b1}} >> ((TIME_BITS >= FLD_W) ? 0 : (FLD_W - TIME_BITS)));
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PROCS);

    // Input fields.
    logic [ID_W-1:0]  in_id;
    logic [FLD_W-1:0] in_arr;
    logic [FLD_W-1:0] in_burst;
    assign in_id    = s_axis_tdata[7:0];
    assign in_arr   = s_axis_tdata[23:8] & ARR_MASK;
    assign in_burst = s_axis_tdata[39:24];

    // Control state.
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   active_reg, active_next;
    logic [TW-1:0]   clock_reg, clock_next;
    logic [AW-1:0]   scan_addr_reg, scan_addr_next;
    logic            rd_valid_reg, rd_valid_next;
    logic            found_reg, found_next;
    logic            out_valid_reg, out_valid_next;

    // Payload state.
    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic [FLD_W-1:0]   best_arr_reg, best_arr_next;
    logic [FLD_W-1:0]   best_burst_reg, best_burst_next;
    logic [FLD_W-1:0]   best_rem_reg, best_rem_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [TW-1:0]      tat_reg, tat_next;
    logic [71:0]        res_data_reg, res_data_next;
    logic [2:0]         res_user_reg, res_user_next;
    logic               res_last_reg, res_last_next;
    logic [71:0]        out_data_reg, out_data_next;
    logic [2:0]         out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    // Table memory and its ports.
    logic [ENTRY_W-1:0] mem [MAX_PROCS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[scan_addr_reg];
        end
    end

    // Fields of the entry that was read last cycle.
    logic [ID_W-1:0]  rd_id;
    logic [FLD_W-1:0] rd_arr;
    logic [FLD_W-1:0] rd_burst;
    logic [FLD_W-1:0] rd_rem;
    assign rd_id    = rd_data_reg[ENTRY_W-1 -: ID_W];
    assign rd_arr   = rd_data_reg[3*FLD_W-1 -: FLD_W];
    assign rd_burst = rd_data_reg[2*FLD_W-1 -: FLD_W];
    assign rd_rem   = rd_data_reg[FLD_W-1:0];

    // Ranking of the candidate against the current pick; one wide compare.
    logic cand_ok;
    logic cand_wins;
    assign cand_ok   = rd_valid_reg && (rd_rem != '0) && (TW'(rd_arr) <= clock_reg);
    assign cand_wins = cand_ok && (!found_reg ||
        ({rd_rem, rd_arr, rd_burst, rd_id} <
         {best_rem_reg, best_arr_reg, best_burst_reg, best_id_reg}));

    // Time step and finish arithmetic.
    logic [TW-1:0] clk_inc;
    logic [WW-1:0] tat_w;
    logic [WW-1:0] burst_w;
    logic [WW-1:0] wait_w;
    logic          fin_now;
    assign clk_inc = (clock_reg == TIME_MAX) ? clock_reg : clock_reg + TW'(1);
    assign tat_w   = WW'(tat_reg);
    assign burst_w = WW'(best_burst_reg);
    assign wait_w  = (tat_w > burst_w) ? tat_w - burst_w : '0;
    assign fin_now = found_reg && (best_rem_reg == FLD_W'(1));

    logic out_free;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        active_next     = active_reg;
        clock_next      = clock_reg;
        scan_addr_next  = scan_addr_reg;
        rd_valid_next   = 1'b0;
        found_next      = found_reg;
        best_id_next    = best_id_reg;
        best_arr_next   = best_arr_reg;
        best_burst_next = best_burst_reg;
        best_rem_next   = best_rem_reg;
        best_idx_next   = best_idx_reg;
        tat_next        = tat_reg;
        res_data_next   = res_data_reg;
        res_user_next   = res_user_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = best_idx_reg;
        mem_wdata       = {best_id_reg, best_arr_reg, best_burst_reg,
                           best_rem_reg - FLD_W'(1)};
        mem_re          = 1'b0;

        // Comparison runs whenever read data is present.
        if (cand_wins)
        begin
            found_next      = 1'b1;
            best_id_next    = rd_id;
            best_arr_next   = rd_arr;
            best_burst_next = rd_burst;
            best_rem_next   = rd_rem;
            best_idx_next   = AW'(scan_addr_reg - AW'(1));
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            active_next = '0;
                            clock_next  = TIME_MAX;
                        end
                        OP_LOAD:
                        begin
                            if (count_reg != FULL_COUNT)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = {in_id, in_arr, in_burst, in_burst};
                                count_next = count_reg + CW'(1);
                                if (in_burst != '0)
                                begin
                                    active_next = active_reg + CW'(1);
                                end
                                if (TW'(in_arr) < clock_reg)
                                begin
                                    clock_next = TW'(in_arr);
                                end
                            end
                            res_data_next = {48'd0, FLD_W'(clock_next), 8'd0};
                            res_user_next = {(count_reg == FULL_COUNT), 2'b00};
                            res_last_next = (active_next == '0);
                            state_next    = S_EMIT;
                        end
                        OP_TICK:
                        begin
                            found_next     = 1'b0;
                            scan_addr_next = '0;
                            state_next     = (count_reg == '0) ? S_WB : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Issue one table read per cycle.
                mem_re         = 1'b1;
                rd_valid_next  = 1'b1;
                scan_addr_next = scan_addr_reg + AW'(1);
                if (CW'(scan_addr_reg) == count_reg - CW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                // Advance time and write back the served entry.
                clock_next = clk_inc;
                tat_next   = clk_inc - TW'(best_arr_reg);
                if (found_reg)
                begin
                    mem_we = 1'b1;
                    if (best_rem_reg == FLD_W'(1))
                    begin
                        active_next = active_reg - CW'(1);
                    end
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                res_data_next = {fin_now ? wait_w[FLD_W-1:0] : FLD_W'(0),
                                 fin_now ? FLD_W'(tat_reg) : FLD_W'(0),
                                 fin_now ? FLD_W'(clock_reg) : FLD_W'(0),
                                 FLD_W'(clock_reg),
                                 found_reg ? best_id_reg : ID_W'(0)};
                res_user_next = {1'b0, fin_now, !found_reg};
                res_last_next = (active_reg == '0);
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                // Hand the result over once the output register is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_user_next  = res_user_reg;
                    out_last_next  = res_last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            active_reg    <= '0;
            clock_reg     <= TIME_MAX;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            clock_reg     <= clock_next;
            scan_addr_reg <= scan_addr_next;
            rd_valid_reg  <= rd_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        best_id_reg    <= best_id_next;
        best_arr_reg   <= best_arr_next;
        best_burst_reg <= best_burst_next;
        best_rem_reg   <= best_rem_next;
        best_idx_reg   <= best_idx_next;
        tat_reg        <= tat_next;
        res_data_reg   <= res_data_next;
        res_user_reg   <= res_user_next;
        res_last_reg   <= res_last_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks on the table bookkeeping and the scan.
    `ASSERT_CLK(a_count_bound, clk, rst_n, count_reg <= FULL_COUNT)
    `ASSERT_CLK(a_active_bound, clk, rst_n, active_reg <= count_reg)
    `ASSERT_CLK(a_scan_nonempty, clk, rst_n, (state_reg == S_SCAN) |-> (count_reg != '0))
    `ASSERT_NEVER(a_idle_finish, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])

endmodule
